>>> sv/pcpd_pkg.sv
// Shared types and constants for the column-of-posts image decoder.
package pcpd_pkg;

	// Field widths.
	localparam int unsigned COL_W    = 11;
	localparam int unsigned LUMP_W   = 24;
	localparam int unsigned DIM_W    = 12;
	localparam int unsigned ADDR_W   = 22;
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned TOP_W    = 13;
	localparam int unsigned PROD_W   = COL_W + DIM_W;
	localparam int unsigned PAL_SIZE = 256;
	localparam int unsigned PAL_W    = $clog2(PAL_SIZE);

	// Queue between the parser and the pixel unit.
	localparam int unsigned Q_DEPTH = 4;
	localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
	localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

	// Stream constants.
	localparam logic [BYTE_W-1:0] END_MARK     = 8'hFF;
	localparam logic [LUMP_W:0]   HEADER_GUARD = 25'd3;
	localparam logic [DIM_W-1:0]  RAW_SKIP     = 12'd3;
	localparam logic [DIM_W-1:0]  TOP_LIMIT    = 12'd4095;

	// Input modes.
	localparam logic [1:0] MODE_LOAD  = 2'd0;
	localparam logic [1:0] MODE_START = 2'd1;
	localparam logic [1:0] MODE_BYTE  = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] CFG_PIC_HEIGHT  = 2'd0;
	localparam logic [1:0] CFG_LUMP_LENGTH = 2'd1;
	localparam logic [1:0] CFG_RAW_COLUMNS = 2'd2;
	localparam logic [1:0] CFG_ZERO_INDEX0 = 2'd3;

	// Parser phases.
	typedef enum logic [2:0] {
		PH_DONE,
		PH_TOP,
		PH_LEN,
		PH_PAD1,
		PH_DATA,
		PH_PAD2,
		PH_RAWSKIP,
		PH_RAWDATA
	} phase_t;

	// Work kinds passed to the pixel unit.
	typedef enum logic [1:0] {
		OP_NONE,
		OP_LOAD,
		OP_PIXEL
	} op_t;

	// Input beat.
	typedef struct packed {
		logic [1:0]        mode;
		logic [COL_W-1:0]  column;
		logic [LUMP_W-1:0] column_offset;
		logic [BYTE_W-1:0] data_byte;
		logic [BYTE_W-1:0] table_index;
		logic [BYTE_W-1:0] table_value;
	} in_beat_t;

	// Output beat.
	typedef struct packed {
		logic              write_valid;
		logic [ADDR_W-1:0] pixel_address;
		logic [BYTE_W-1:0] pixel_value;
		logic              column_done;
	} out_beat_t;

	// Configuration register set.
	typedef struct packed {
		logic [DIM_W-1:0]  pic_height;
		logic [LUMP_W-1:0] lump_length;
		logic              raw_columns;
		logic              zero_index0;
	} cfg_t;

	// Queue entry: one classified item.
	typedef struct packed {
		op_t              op;
		logic             done;
		logic [COL_W-1:0] column;
		logic [DIM_W-1:0] row;
		logic [PAL_W-1:0] idx;
		logic [BYTE_W-1:0] val;
	} work_t;

endpackage

>>> sv/patch_column_post_decoder.sv
// Path: an accepted input beat is written into the queue, then popped into stage one (remap table read
// and address multiply), then moved into stage two (row added), which drives the result beat.
// Throughput: one input beat per cycle while in_stall is low; in_stall rises when the queue is full.
// A four-entry queue lets the parser keep accepting while the output stalls, until it fills.
// Reset: asynchronous, active low; clears parser state, queue and stage valids,
// sets pic_height to 1 and the other registers to 0; the remap table is not cleared.
module patch_column_post_decoder (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  pcpd_pkg::in_beat_t                in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output pcpd_pkg::out_beat_t               out_data,
	input  logic                              cfg_we,
	input  logic [1:0]                        cfg_index,
	input  logic [pcpd_pkg::LUMP_W-1:0]       cfg_data
);

	pcpd_pkg::cfg_t  cfg_q;
	pcpd_pkg::work_t work, head;
	logic            push, pop, q_full, q_not_empty;

	assign in_stall = q_full;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pic_height  <= pcpd_pkg::DIM_W'(1);
			cfg_q.lump_length <= '0;
			cfg_q.raw_columns <= 1'b0;
			cfg_q.zero_index0 <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pcpd_pkg::CFG_PIC_HEIGHT:  cfg_q.pic_height  <= cfg_data[pcpd_pkg::DIM_W-1:0];
				pcpd_pkg::CFG_LUMP_LENGTH: cfg_q.lump_length <= cfg_data;
				pcpd_pkg::CFG_RAW_COLUMNS: cfg_q.raw_columns <= cfg_data[0];
				pcpd_pkg::CFG_ZERO_INDEX0: cfg_q.zero_index0 <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	pcpd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_data  (in_data),
		.cfg      (cfg_q),
		.q_full   (q_full),
		.push     (push),
		.work     (work)
	);

	pcpd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (work),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (head)
	);

	pcpd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_not_empty (q_not_empty),
		.head        (head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data)
	);

endmodule

>>> sv/pcpd_front.sv
// Stream parser: accepts beats, tracks post structure and classifies each beat.
module pcpd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  pcpd_pkg::in_beat_t in_data,
	input  pcpd_pkg::cfg_t     cfg,
	input  logic               q_full,
	output logic               push,
	output pcpd_pkg::work_t    work
);

	pcpd_pkg::phase_t                   phase_q, phase_d;
	logic [pcpd_pkg::COL_W-1:0]         column_q, column_d;
	logic [pcpd_pkg::LUMP_W-1:0]        pos_q, pos_d, pos_inc;
	logic signed [pcpd_pkg::TOP_W-1:0]  top_q, top_d;
	logic [pcpd_pkg::BYTE_W-1:0]        raw_len_q, raw_len_d;
	logic [pcpd_pkg::DIM_W-1:0]         wr_len_q, wr_len_d;
	logic [pcpd_pkg::DIM_W-1:0]         cnt_q, cnt_d, cnt_inc;
	logic [pcpd_pkg::DIM_W-1:0]         room;
	logic [pcpd_pkg::DIM_W+1:0]         top_sum;
	logic                               top_le;
	logic                               hdr_ok_start, hdr_ok_next;
	logic [pcpd_pkg::BYTE_W-1:0]        b;

	assign push = in_valid && !q_full;
	assign b    = in_data.data_byte;

	// Shared arithmetic for the current beat.
	assign pos_inc      = pos_q + 1'b1;
	assign cnt_inc      = cnt_q + 1'b1;
	assign hdr_ok_start = ({1'b0, in_data.column_offset} + pcpd_pkg::HEADER_GUARD)
		< {1'b0, cfg.lump_length};
	assign hdr_ok_next  = ({1'b0, pos_inc} + pcpd_pkg::HEADER_GUARD)
		< {1'b0, cfg.lump_length};
	assign top_le  = $signed({5'b0, b}) <= top_q;
	assign top_sum = {2'b0, top_q[pcpd_pkg::DIM_W-1:0]} + {6'b0, b};
	assign room    = cfg.pic_height - top_q[pcpd_pkg::DIM_W-1:0];

	// Next parse state and the classified work entry.
	always_comb begin
		phase_d   = phase_q;
		column_d  = column_q;
		pos_d     = pos_q;
		top_d     = top_q;
		raw_len_d = raw_len_q;
		wr_len_d  = wr_len_q;
		cnt_d     = cnt_q;
		work      = '0;
		work.op   = pcpd_pkg::OP_NONE;
		unique case (in_data.mode)
			pcpd_pkg::MODE_LOAD: begin
				work.op  = pcpd_pkg::OP_LOAD;
				work.idx = in_data.table_index;
				work.val = in_data.table_value;
			end
			pcpd_pkg::MODE_START: begin
				column_d  = in_data.column;
				pos_d     = in_data.column_offset;
				top_d     = '1;
				raw_len_d = '0;
				wr_len_d  = '0;
				cnt_d     = '0;
				if (cfg.raw_columns) begin
					phase_d = pcpd_pkg::PH_RAWSKIP;
				end else if (hdr_ok_start) begin
					phase_d = pcpd_pkg::PH_TOP;
				end else begin
					phase_d   = pcpd_pkg::PH_DONE;
					work.done = 1'b1;
				end
			end
			pcpd_pkg::MODE_BYTE: begin
				if (phase_q != pcpd_pkg::PH_DONE) begin
					pos_d = pos_inc;
				end
				work.column = column_q;
				work.idx    = b;
				unique case (phase_q)
					pcpd_pkg::PH_DONE: begin
					end
					pcpd_pkg::PH_TOP: begin
						if (b == pcpd_pkg::END_MARK) begin
							phase_d   = pcpd_pkg::PH_DONE;
							work.done = 1'b1;
						end else begin
							if (top_le) begin
								if (top_sum > {2'b0, pcpd_pkg::TOP_LIMIT}) begin
									top_d = {1'b0, pcpd_pkg::TOP_LIMIT};
								end else begin
									top_d = top_sum[pcpd_pkg::TOP_W-1:0];
								end
							end else begin
								top_d = {5'b0, b};
							end
							phase_d = pcpd_pkg::PH_LEN;
						end
					end
					pcpd_pkg::PH_LEN: begin
						raw_len_d = b;
						if (top_q >= $signed({1'b0, cfg.pic_height})) begin
							wr_len_d = '0;
						end else if ({4'b0, b} < room) begin
							wr_len_d = {4'b0, b};
						end else begin
							wr_len_d = room;
						end
						cnt_d   = '0;
						phase_d = pcpd_pkg::PH_PAD1;
					end
					pcpd_pkg::PH_PAD1: begin
						phase_d = (raw_len_q != '0) ? pcpd_pkg::PH_DATA : pcpd_pkg::PH_PAD2;
					end
					pcpd_pkg::PH_DATA: begin
						if (cnt_q < wr_len_q) begin
							work.op  = pcpd_pkg::OP_PIXEL;
							work.row = top_q[pcpd_pkg::DIM_W-1:0] + cnt_q;
						end
						cnt_d = cnt_inc;
						if (cnt_inc >= {4'b0, raw_len_q}) begin
							phase_d = pcpd_pkg::PH_PAD2;
						end
					end
					pcpd_pkg::PH_PAD2: begin
						if (hdr_ok_next) begin
							phase_d = pcpd_pkg::PH_TOP;
						end else begin
							phase_d   = pcpd_pkg::PH_DONE;
							work.done = 1'b1;
						end
					end
					pcpd_pkg::PH_RAWSKIP: begin
						cnt_d = cnt_inc;
						if (cnt_inc >= pcpd_pkg::RAW_SKIP) begin
							cnt_d = '0;
							if (cfg.pic_height == '0) begin
								phase_d   = pcpd_pkg::PH_DONE;
								work.done = 1'b1;
							end else begin
								phase_d = pcpd_pkg::PH_RAWDATA;
							end
						end
					end
					pcpd_pkg::PH_RAWDATA: begin
						work.op  = pcpd_pkg::OP_PIXEL;
						work.row = cnt_q;
						cnt_d    = cnt_inc;
						if (cnt_inc >= cfg.pic_height) begin
							phase_d   = pcpd_pkg::PH_DONE;
							work.done = 1'b1;
						end
					end
					default: begin
						phase_d = pcpd_pkg::PH_DONE;
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	// Parse state advances only on an accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= pcpd_pkg::PH_DONE;
			column_q  <= '0;
			pos_q     <= '0;
			top_q     <= '1;
			raw_len_q <= '0;
			wr_len_q  <= '0;
			cnt_q     <= '0;
		end else if (push) begin
			phase_q   <= phase_d;
			column_q  <= column_d;
			pos_q     <= pos_d;
			top_q     <= top_d;
			raw_len_q <= raw_len_d;
			wr_len_q  <= wr_len_d;
			cnt_q     <= cnt_d;
		end
	end

endmodule

>>> sv/pcpd_queue.sv
// Small FIFO of classified work between the parser and the pixel unit.
module pcpd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  pcpd_pkg::work_t push_data,
	input  logic            pop,
	output logic            full,
	output logic            not_empty,
	output pcpd_pkg::work_t head
);

	pcpd_pkg::work_t               slot_q [pcpd_pkg::Q_DEPTH];
	logic [pcpd_pkg::Q_PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [pcpd_pkg::Q_CNT_W-1:0]  count_q;

	assign full      = count_q == pcpd_pkg::Q_CNT_W'(pcpd_pkg::Q_DEPTH);
	assign not_empty = count_q != '0;
	assign head      = slot_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> sv/pcpd_back.sv
// Pixel unit: remap table, address multiply and the output register.
module pcpd_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pcpd_pkg::cfg_t       cfg,
	input  logic                 q_not_empty,
	input  pcpd_pkg::work_t      head,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output pcpd_pkg::out_beat_t  out_data
);

	logic [pcpd_pkg::BYTE_W-1:0] remap_mem [pcpd_pkg::PAL_SIZE];

	logic                         valid_s1;
	logic                         pixel_s1;
	logic                         done_s1;
	logic                         idx_zero_s1;
	logic [pcpd_pkg::DIM_W-1:0]   row_s1;
	logic [pcpd_pkg::PROD_W-1:0]  prod_s1;
	logic [pcpd_pkg::BYTE_W-1:0]  rd_s1;
	logic                         valid_s2;
	pcpd_pkg::out_beat_t          data_s2;
	logic                         advance;
	logic [pcpd_pkg::PROD_W-1:0]  addr_sum;

	// The output stage moves when it is empty or its beat is taken.
	assign advance   = !valid_s2 || !out_stall;
	assign pop       = q_not_empty && (!valid_s1 || advance);
	assign out_valid = valid_s2;
	assign out_data  = data_s2;
	assign addr_sum  = prod_s1 + {{(pcpd_pkg::PROD_W-pcpd_pkg::DIM_W){1'b0}}, row_s1};

	// Remap table: written by load entries, read for every popped entry.
	always_ff @(posedge clk) begin
		if (pop) begin
			if (head.op == pcpd_pkg::OP_LOAD) begin
				remap_mem[head.idx] <= head.val;
			end
			rd_s1 <= remap_mem[head.idx];
		end
	end

	// Stage one payload: column times height.
	always_ff @(posedge clk) begin
		if (pop) begin
			pixel_s1    <= head.op == pcpd_pkg::OP_PIXEL;
			done_s1     <= head.done;
			idx_zero_s1 <= head.idx == '0;
			row_s1      <= head.row;
			prod_s1     <= head.column * cfg.pic_height;
		end
	end

	// Stage two payload: final address and remapped value, zero when no pixel is written.
	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			data_s2.write_valid   <= pixel_s1;
			data_s2.pixel_address <= pixel_s1 ? addr_sum[pcpd_pkg::ADDR_W-1:0] : '0;
			data_s2.pixel_value   <= (pixel_s1 && !(cfg.zero_index0 && idx_zero_s1)) ?
				rd_s1 : '0;
			data_s2.column_done   <= done_s1;
		end
	end

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (pop) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

endmodule
